FILE: rtl/g2enu_pkg.sv
package g2enu_pkg;

    // product request to the shared multiplier
    typedef struct packed {
        logic               go;
        logic signed [40:0] a;
        logic signed [33:0] b;
    } mul_req_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/g2enu_cordic.sv
module g2enu_cordic
    import g2enu_pkg::*;
#(
    parameter int FRAC  = 30,
    parameter int STEPS = 28
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);
    localparam logic signed [33:0] K0 = 34'(652032874 >>> (30 - FRAC));

    logic signed [33:0] x_reg, x_next, y_reg, y_next, sx, sy;
    logic signed [33:0] z_reg, z_next, at;
    logic               flip_reg, flip_next, busy_reg, busy_next, done_reg, done_next;
    logic [4:0]         i_reg, i_next;
    logic signed [33:0] za;

    always_comb
    begin
        za        = 34'(angle);
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        i_next    = i_reg;
        done_next = 1'b0;
        sx        = x_reg >>> i_reg;
        sy        = y_reg >>> i_reg;
        at        = 34'(atan_entry(i_reg));
        if (start)
        begin
            x_next    = K0;
            y_next    = '0;
            i_next    = '0;
            busy_next = 1'b1;
            flip_next = 1'b0;
            z_next    = za;
            if (za > 34'sd1073741824)
            begin
                z_next    = za - 34'sd2147483648;
                flip_next = 1'b1;
            end
            else if (za < -34'sd1073741824)
            begin
                z_next    = za + 34'sd2147483648;
                flip_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                z_next = z_reg + at;
            end
            i_next = i_reg + 5'd1;
            if (32'(i_reg) == STEPS - 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (flip_reg)
                begin
                    x_next = -x_next;
                    y_next = -y_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        i_reg    <= i_next;
    end

    assign done  = done_reg;
    assign sin_q = y_reg[31:0];
    assign cos_q = x_reg[31:0];
endmodule

FILE: rtl/g2enu_mul.sv
module g2enu_mul
    import g2enu_pkg::*;
#(
    parameter int FRAC = 30
)
(
    input  logic               clk,
    input  mul_req_t           req,
    output logic signed [47:0] prod
);
    // sign-magnitude multiply, rounded half away from zero.
    // go loads the operands; the next cycle forms the low half product
    // (b[16:0]), the cycle after that the high half (b[33:17]) and the sum.
    logic [40:0] ma;
    logic [33:0] mb;
    logic        neg_reg;
    logic [40:0] ma_reg;
    logic [33:0] mb_reg;
    logic        hi_reg;
    logic [57:0] part;
    logic [57:0] lo_reg;
    logic [75:0] full;
    logic [75:0] rnd;

    assign ma = req.a[40] ? 41'(-req.a) : 41'(req.a);
    assign mb = req.b[33] ? 34'(-req.b) : 34'(req.b);

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            neg_reg <= req.a[40] ^ req.b[33];
            ma_reg  <= ma;
            mb_reg  <= mb;
            hi_reg  <= 1'b0;
        end
        else
            hi_reg <= 1'b1;
        lo_reg <= part;
    end

    assign part = 58'(ma_reg) * 58'(hi_reg ? mb_reg[33:17] : mb_reg[16:0]);
    assign full = (76'(part) << 17) + 76'(lo_reg);
    assign rnd  = (full + (76'd1 << (FRAC - 1))) >> FRAC;
    assign prod = neg_reg ? -48'(rnd) : 48'(rnd);
endmodule

FILE: rtl/geodetic_to_local_enu_top.sv
// Geodetic fix to local east-north-up converter on a spherical Earth.
// Input channel: in_valid/in_stall with latitude, longitude, altitude_mm.
// Output channel: out_valid/out_stall with east_mm, north_mm, up_mm and
// origin_taken. One result per request.
// APB port: register 0 is earth_radius_m (24 bits), reset 6371000.
// From the accepting edge to out_valid the latitude and then the longitude
// CORDIC run, then the product schedule runs on the multiplier; one CORDIC
// engine and one multiplier are shared by all steps. in_stall is high while
// a request is in flight. The result sits in an output register; while
// out_stall is high it holds and no new request is taken. The next request
// is taken only once the result has been accepted.
// After reset the first fix becomes the origin, as does any fix that
// follows an all-zero fix.
module geodetic_to_local_enu_top
    import g2enu_pkg::*;
#(
    parameter int TRIG_FRACTION_BITS = 30,
    parameter int CORDIC_STEPS       = 28
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic signed [27:0] altitude_mm,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [40:0] east_mm,
    output logic signed [40:0] north_mm,
    output logic signed [40:0] up_mm,
    output logic               origin_taken,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam logic [3:0] S_IDLE = 4'd0, S_LAT = 4'd1, S_LON = 4'd2, S_MUL = 4'd3,
                           S_MW1 = 4'd4, S_MW2 = 4'd5, S_OUT = 4'd6;
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic signed [47:0] OMAX = 48'sd1099511627775;
    localparam logic signed [47:0] OMIN = -48'sd1099511627776;

    logic [3:0]  st_reg, st_next;
    logic [3:0]  k_reg;
    logic [23:0] radius_reg;
    logic signed [31:0] lon_reg;
    logic signed [31:0] sl_reg, cl_reg, so_reg, co_reg;
    logic signed [31:0] osl_reg, ocl_reg, oso_reg, oco_reg;
    logic signed [35:0] orad_reg, r_reg;
    logic        prevz_reg, take_reg;
    logic signed [47:0] ux_reg, uy_reg, h_reg, e_reg, n_reg, u_reg, t_reg;
    logic signed [47:0] prod, acc;
    logic               c_start, c_done;
    logic signed [31:0] c_angle, c_sin, c_cos;
    mul_req_t           mreq;
    logic               in_acc;

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_RADIUS) ? {8'd0, radius_reg} : 32'd0;
    assign in_stall = (st_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= 24'd6371000;
        else if (psel && penable && pwrite && paddr == REG_RADIUS)
            radius_reg <= pwdata[23:0];
    end

    assign c_start = in_acc || (st_reg == S_LAT && c_done);
    assign c_angle = in_acc ? latitude : lon_reg;

    g2enu_cordic #(.FRAC(TRIG_FRACTION_BITS), .STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(c_start), .angle(c_angle),
        .done(c_done), .sin_q(c_sin), .cos_q(c_cos)
    );

    // product schedule, one per k
    always_comb
    begin
        mreq.go = (st_reg == S_MUL);
        mreq.a  = '0;
        mreq.b  = '0;
        case (k_reg)
            4'd0:  begin mreq.a = 41'(cl_reg);  mreq.b = 34'(co_reg); end
            4'd1:  begin mreq.a = 41'(cl_reg);  mreq.b = 34'(so_reg); end
            4'd2:  begin mreq.a = 41'(oco_reg); mreq.b = 34'(ux_reg); end
            4'd3:  begin mreq.a = 41'(oso_reg); mreq.b = 34'(uy_reg); end
            4'd4:  begin mreq.a = 41'(oco_reg); mreq.b = 34'(uy_reg); end
            4'd5:  begin mreq.a = 41'(oso_reg); mreq.b = 34'(ux_reg); end
            4'd6:  begin mreq.a = 41'(ocl_reg); mreq.b = 34'(sl_reg); end
            4'd7:  begin mreq.a = 41'(osl_reg); mreq.b = 34'(h_reg);  end
            4'd8:  begin mreq.a = 41'(ocl_reg); mreq.b = 34'(h_reg);  end
            4'd9:  begin mreq.a = 41'(osl_reg); mreq.b = 34'(sl_reg); end
            4'd10: begin mreq.a = 41'(r_reg);   mreq.b = 34'(e_reg);  end
            4'd11: begin mreq.a = 41'(r_reg);   mreq.b = 34'(n_reg);  end
            default: begin mreq.a = 41'(r_reg); mreq.b = 34'(u_reg);  end
        endcase
    end

    g2enu_mul #(.FRAC(TRIG_FRACTION_BITS)) u_mul (.clk(clk), .req(mreq), .prod(prod));

    function automatic logic signed [40:0] sat(input logic signed [47:0] v);
        if (v > OMAX)
            return OMAX[40:0];
        else if (v < OMIN)
            return OMIN[40:0];
        return v[40:0];
    endfunction

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (in_acc) st_next = S_LAT;
            S_LAT:  if (c_done) st_next = S_LON;
            S_LON:  if (c_done) st_next = S_MUL;
            S_MUL:  st_next = S_MW1;
            S_MW1:  st_next = S_MW2;
            S_MW2:  st_next = (k_reg == 4'd12) ? S_OUT : S_MUL;
            S_OUT:  if (!out_stall) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            prevz_reg <= 1'b1;
            osl_reg   <= '0;
            ocl_reg   <= '0;
            oso_reg   <= '0;
            oco_reg   <= '0;
            orad_reg  <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (in_acc)
                prevz_reg <= (latitude == 0) && (longitude == 0) && (altitude_mm == 0);
            if (st_reg == S_LON && c_done && take_reg)
            begin
                osl_reg  <= sl_reg;
                ocl_reg  <= cl_reg;
                oso_reg  <= c_sin;
                oco_reg  <= c_cos;
                orad_reg <= r_reg;
            end
        end
    end

    assign acc = t_reg + prod;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            lon_reg  <= longitude;
            take_reg <= prevz_reg;
            r_reg    <= 36'(radius_reg) * 36'd1000 + 36'(altitude_mm);
        end
        if (st_reg == S_LAT && c_done)
        begin
            sl_reg <= c_sin;
            cl_reg <= c_cos;
        end
        if (st_reg == S_LON && c_done)
        begin
            so_reg <= c_sin;
            co_reg <= c_cos;
            k_reg  <= '0;
        end
        if (st_reg == S_MW2)
        begin
            k_reg <= k_reg + 4'd1;
            case (k_reg)
                4'd0:  ux_reg <= prod;
                4'd1:  uy_reg <= prod;
                4'd2:  t_reg <= prod;
                4'd3:  h_reg <= acc;
                4'd4:  t_reg <= prod;
                4'd5:  e_reg <= t_reg - prod;
                4'd6:  t_reg <= prod;
                4'd7:  n_reg <= t_reg - prod;
                4'd8:  t_reg <= prod;
                4'd9:  u_reg <= acc;
                4'd10: east_mm <= sat(prod);
                4'd11: north_mm <= sat(prod);
                default:
                begin
                    up_mm        <= sat(prod - 48'(orad_reg));
                    origin_taken <= take_reg;
                end
            endcase
        end
    end

    assign out_valid = (st_reg == S_OUT);

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !in_acc) else $error("request taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        c_done |-> (st_reg == S_LAT || st_reg == S_LON)) else $error("stray cordic done");
`endif
endmodule

FILE: sim/enu_fix_checker.sv
module enu_fix_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic signed [27:0] altitude_mm,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [40:0] east_mm,
    input  logic signed [40:0] north_mm,
    input  logic signed [40:0] up_mm,
    input  logic               origin_taken,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 mismatches,
    output int                 awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC  = 30;
    localparam int STEPS = 28;
    localparam logic [1:0] RADIUS_ADDR = 2'd0;
    localparam longint OUT_HI = 64'sd1099511627775;
    localparam longint OUT_LO = -64'sd1099511627776;

    typedef struct {
        logic signed [40:0] east;
        logic signed [40:0] north;
        logic signed [40:0] up;
        logic               taken;
    } enu_fix_t;

    // arctan(2^-i) in binary angle units
    localparam longint ARCTAN [32] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
        'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001,
        0, 0
    };

    logic [23:0]   radius_m;
    logic signed [31:0] org_sin_lat, org_cos_lat, org_sin_lon, org_cos_lon;
    longint        org_radius;
    logic          last_fix_zero;
    enu_fix_t      fixes_due[$];

    assign awaiting = fixes_due.size();

    function automatic void rotate_angle(input longint ang, output longint s,
                                         output longint c);
        longint x, y, z, t;
        bit     flip;
        x = 652032874 >>> (30 - FRAC);
        y = 0;
        z = ang;
        flip = 0;
        if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30))
        begin
            z = (z > 0) ? z - (64'sd1 <<< 31) : z + (64'sd1 <<< 31);
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARCTAN[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARCTAN[i];
            end
            x = t;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = longint'(int'(y));
        c = longint'(int'(x));
    endfunction

    // a*b / 2^FRAC, half away from zero
    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] ma, mb, p;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ma = 128'(a < 0 ? -a : a);
        mb = 128'(b < 0 ? -b : b);
        p = (ma * mb + (128'd1 << (FRAC - 1))) >> FRAC;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic signed [40:0] clip41(input longint v);
        if (v > OUT_HI)
            v = OUT_HI;
        if (v < OUT_LO)
            v = OUT_LO;
        return v[40:0];
    endfunction

    function automatic enu_fix_t locate_fix(input logic signed [31:0] lat,
                                            input logic signed [31:0] lon,
                                            input logic signed [27:0] alt);
        enu_fix_t f;
        longint sl, cl, so, co, r, ux, uy, uz, h, e, n, u;
        rotate_angle(longint'(lat), sl, cl);
        rotate_angle(longint'(lon), so, co);
        r = longint'(radius_m) * 1000 + longint'(alt);
        f.taken = last_fix_zero;
        if (last_fix_zero)
        begin
            org_sin_lat = sl[31:0];
            org_cos_lat = cl[31:0];
            org_sin_lon = so[31:0];
            org_cos_lon = co[31:0];
            org_radius  = r;
        end
        last_fix_zero = (lat == 0 && lon == 0 && alt == 0);
        ux = qmul(cl, co);
        uy = qmul(cl, so);
        uz = sl;
        h = qmul(org_cos_lon, ux) + qmul(org_sin_lon, uy);
        e = qmul(org_cos_lon, uy) - qmul(org_sin_lon, ux);
        n = qmul(org_cos_lat, uz) - qmul(org_sin_lat, h);
        u = qmul(org_cos_lat, h) + qmul(org_sin_lat, uz);
        f.east  = clip41(qmul(r, e));
        f.north = clip41(qmul(r, n));
        f.up    = clip41(qmul(r, u) - org_radius);
        return f;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        enu_fix_t w;
        if (!rst_n)
        begin
            radius_m      = 24'd6371000;
            org_sin_lat   = 0;
            org_cos_lat   = 0;
            org_sin_lon   = 0;
            org_cos_lon   = 0;
            org_radius    = 0;
            last_fix_zero = 1;
            fixes_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == RADIUS_ADDR)
                radius_m = pwdata[23:0];
            if (in_valid && !in_stall)
                fixes_due.push_back(locate_fix(latitude, longitude, altitude_mm));
            if (out_valid && !out_stall)
            begin
                if (fixes_due.size() == 0)
                    report("unexpected result", east_mm, 0);
                else
                begin
                    w = fixes_due.pop_front();
                    if (east_mm !== w.east)
                        report("east_mm", east_mm, w.east);
                    if (north_mm !== w.north)
                        report("north_mm", north_mm, w.north);
                    if (up_mm !== w.up)
                        report("up_mm", up_mm, w.up);
                    if (origin_taken !== w.taken)
                        report("origin_taken", origin_taken, w.taken);
                end
            end
        end
    end
endmodule

FILE: sim/tb_geodetic_to_local_enu_top.sv
module tb_geodetic_to_local_enu_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] RADIUS_ADDR = 2'd0;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS = 390;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [31:0] latitude = 0;
    logic signed [31:0] longitude = 0;
    logic signed [27:0] altitude_mm = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [40:0] east_mm, north_mm, up_mm;
    logic               origin_taken;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [1:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    int  mismatches, awaiting;
    int  hold_cycles = 0;
    bit  steady = 0;
    int  idle_run = 0;

    always #5 clk = ~clk;

    geodetic_to_local_enu_top uut (.*);

    enu_fix_checker enu_chk (.*);

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= !steady && ($urandom_range(99, 0) < 12);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic set_radius(input logic [23:0] meters);
        wait (awaiting == 0);
        repeat (120) @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= RADIUS_ADDR;
        pwdata  <= {8'($urandom), meters};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
    endtask

    task automatic send_fix(input logic signed [31:0] lat, input logic signed [31:0] lon,
                            input logic signed [27:0] alt);
        int gap;
        if (!steady && $urandom_range(99, 0) < 12)
        begin
            in_valid <= 0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1;
        latitude    <= lat;
        longitude   <= lon;
        altitude_mm <= alt;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic signed [31:0] rand_lat();
        return $signed($urandom_range(32'h80000000, 0)) - 32'sh40000000;
    endfunction

    function automatic logic signed [27:0] rand_alt();
        return 28'($signed($urandom_range(101000000, 0)) - 1000000);
    endfunction

    task automatic send_random_fix();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 5)
            send_fix(0, 0, 0);
        else if (pick < 15)
            send_fix(($urandom & 1) ? 32'sh40000000 : -32'sh40000000,
                     ($urandom & 1) ? 32'sh7FFFFFFF : 32'sh80000000,
                     ($urandom & 1) ? 28'sd100000000 : -28'sd1000000);
        else if (pick < 25)
            send_fix(rand_lat(), $urandom, 28'($urandom_range(3000, 0) - 1000));
        else
            send_fix(rand_lat(), $urandom, rand_alt());
    endtask

    task automatic release_input();
        in_valid <= 0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [23:0] radii [5];
        radii = '{24'd6371000, 24'd1, 24'd16777215, 24'($urandom_range(16777215, 1)),
                  24'd6371000};
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: first fix is the origin, then extremes and zero fixes
        send_fix(32'sh01000000, 32'sh02000000, 28'sd12345);
        send_fix(32'sh40000000, 32'sh7FFFFFFF, 28'sd100000000);
        send_fix(-32'sh40000000, 32'sh80000000, -28'sd1000000);
        send_fix(0, 32'sh40000000, 0);
        send_fix(0, -32'sh40000000, 0);
        send_fix(0, 0, 0);
        send_fix(32'sh20000000, 32'sh60000000, 28'sd500);
        send_fix(0, 0, 0);
        send_fix(0, 0, 0);
        send_fix(-32'sh3FFFFFFF, 32'sh40000001, -28'sd999999);
        send_fix(32'sh00000001, 32'sh00000001, 28'sd1);
        send_fix(0, 0, 1);
        send_fix(0, 0, 0);
        send_fix(32'sh40000000, 32'sh80000000, 28'sd0);
        release_input();

        for (int ph = 0; ph < 5; ph++)
        begin
            set_radius(radii[ph]);
            if (ph == 1)
            begin
                send_fix(0, 0, 0);
                send_fix(32'sh40000000, 32'sh7FFFFFFF, 28'sd100000000);
            end
            steady = (ph == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 3 && k == 100)
                    hold_cycles = 300;
                if (ph == 3 && k == 200)
                begin
                    release_input();
                    wait (awaiting == 0);
                end
                send_random_fix();
            end
            steady = 0;
            release_input();
        end

        wait (awaiting == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/g2enu_pkg.sv
rtl/g2enu_cordic.sv
rtl/g2enu_mul.sv
rtl/geodetic_to_local_enu_top.sv
sim/enu_fix_checker.sv
sim/tb_geodetic_to_local_enu_top.sv
